[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gha_pkg.sv]
package gha_pkg;

  // Fixed widths of the request and result fields.
  localparam int KIND_W         = 3;
  localparam int IDX_FIELD_W    = 8;
  localparam int GEN_FIELD_W    = 16;
  localparam int STABLE_FIELD_W = 32;
  // Common width used to compare a search key against a stored stable id.
  localparam int KEY_CMP_W      = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE     = 3'd0,
    KIND_DESTROY    = 3'd1,
    KIND_IS_ALIVE   = 3'd2,
    KIND_GET_STABLE = 3'd3,
    KIND_FIND       = 3'd4,
    KIND_MAKE       = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_CREATE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      found;
    logic [IDX_FIELD_W-1:0]    index;
    logic [GEN_FIELD_W-1:0]    generation;
    logic [STABLE_FIELD_W-1:0] stable;
    logic                      full_error;
  } result_t;

endpackage

[hdl/generational_handle_allocator.sv]
// Sequence: a lookup reads the slot table, then decides and writes back; a create that reuses a
//   freed slot first pops the free stack; a find by stable id reads the used slots in order.
// Handshake: one request at a time, accepted the cycle after the previous result enters the
//   output register.
// Reset: synchronous, active low. Counters clear at once; no table sweep is needed because
//   the used-slot count bounds every read of the slot table.
module generational_handle_allocator #(
  parameter int SLOT_COUNT  = 256,
  parameter int GEN_BITS    = 16,
  parameter int STABLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_slot_index,
  input  logic [15:0] in_handle_generation,
  input  logic [31:0] in_search_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [7:0]  out_index,
  output logic [15:0] out_generation,
  output logic [31:0] out_stable,
  output logic        out_full_error
);

  // The slot table keeps one word per slot: the alive mark on top, then the
  // generation, then the stable id. The free stack keeps slot indexes, and its
  // top of stack is the free count held in the controller.
  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int ENTRY_W = 1 + GEN_BITS + STABLE_BITS;

  logic               slot_rd_en;
  logic [IDX_W-1:0]   slot_rd_addr;
  logic [ENTRY_W-1:0] slot_rd_data;
  logic               slot_wr_en;
  logic [IDX_W-1:0]   slot_wr_addr;
  logic [ENTRY_W-1:0] slot_wr_data;
  logic               stk_rd_en;
  logic [IDX_W-1:0]   stk_rd_addr;
  logic [IDX_W-1:0]   stk_rd_data;
  logic               stk_wr_en;
  logic [IDX_W-1:0]   stk_wr_addr;
  logic [IDX_W-1:0]   stk_wr_data;

  logic             res_valid;
  logic             res_take;
  gha_pkg::result_t res;

  // Output register. It lets the controller finish a request while the
  // previous result still waits for the downstream side.
  logic             out_valid_r, out_valid_nxt;
  gha_pkg::result_t out_res_r, out_res_nxt;

  gha_ram #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (ENTRY_W)
  ) u_slot_table (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  gha_ram #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (IDX_W)
  ) u_free_stack (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data)
  );

  // The controller sequences each request through the two memories: a read
  // in one cycle, the decision and write back in the next. A find walks the
  // used range one slot per cycle with the next read overlapping the compare.
  gha_ctrl #(
    .SLOT_COUNT  (SLOT_COUNT),
    .GEN_BITS    (GEN_BITS),
    .STABLE_BITS (STABLE_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_valid),
    .req_stall      (in_stall),
    .req_kind       (in_kind),
    .req_slot_index (in_slot_index),
    .req_generation (in_handle_generation),
    .req_search_key (in_search_key),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res),
    .slot_rd_en     (slot_rd_en),
    .slot_rd_addr   (slot_rd_addr),
    .slot_rd_data   (slot_rd_data),
    .slot_wr_en     (slot_wr_en),
    .slot_wr_addr   (slot_wr_addr),
    .slot_wr_data   (slot_wr_data),
    .stk_rd_en      (stk_rd_en),
    .stk_rd_addr    (stk_rd_addr),
    .stk_rd_data    (stk_rd_data),
    .stk_wr_en      (stk_wr_en),
    .stk_wr_addr    (stk_wr_addr),
    .stk_wr_data    (stk_wr_data)
  );

  // The register can take a new result when it is empty or being emptied.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid && res_take) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_res_r.found;
  assign out_index      = out_res_r.index;
  assign out_generation = out_res_r.generation;
  assign out_stable     = out_res_r.stable;
  assign out_full_error = out_res_r.full_error;

endmodule

[hdl/gha_ram.sv]
module gha_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/gha_ctrl.sv]
`include "assert_macros.svh"

module gha_ctrl #(
  parameter int SLOT_COUNT  = 256,
  parameter int GEN_BITS    = 16,
  parameter int STABLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request side
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [gha_pkg::KIND_W-1:0]           req_kind,
  input  logic [gha_pkg::IDX_FIELD_W-1:0]      req_slot_index,
  input  logic [gha_pkg::GEN_FIELD_W-1:0]      req_generation,
  input  logic [gha_pkg::STABLE_FIELD_W-1:0]   req_search_key,
  // Result side
  output logic                                 res_valid,
  input  logic                                 res_take,
  output gha_pkg::result_t                     res,
  // Slot table memory
  output logic                                 slot_rd_en,
  output logic [$clog2(SLOT_COUNT)-1:0]        slot_rd_addr,
  input  logic [GEN_BITS+STABLE_BITS:0]        slot_rd_data,
  output logic                                 slot_wr_en,
  output logic [$clog2(SLOT_COUNT)-1:0]        slot_wr_addr,
  output logic [GEN_BITS+STABLE_BITS:0]        slot_wr_data,
  // Free stack memory
  output logic                                 stk_rd_en,
  output logic [$clog2(SLOT_COUNT)-1:0]        stk_rd_addr,
  input  logic [$clog2(SLOT_COUNT)-1:0]        stk_rd_data,
  output logic                                 stk_wr_en,
  output logic [$clog2(SLOT_COUNT)-1:0]        stk_wr_addr,
  output logic [$clog2(SLOT_COUNT)-1:0]        stk_wr_data
);

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int ENTRY_W = 1 + GEN_BITS + STABLE_BITS;

  gha_pkg::state_t state_r, state_nxt;
  gha_pkg::kind_t  kind_r, kind_nxt;
  logic [gha_pkg::IDX_FIELD_W-1:0]    idx_r, idx_nxt;
  logic [GEN_BITS-1:0]                gen_r, gen_nxt;
  logic [gha_pkg::STABLE_FIELD_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]                   slot_r, slot_nxt;
  logic                               fresh_r, fresh_nxt;
  logic [IDX_W-1:0]                   scan_r, scan_nxt;
  logic [CNT_W-1:0]                   free_count_r, free_count_nxt;
  logic [CNT_W-1:0]                   used_r, used_nxt;
  logic [STABLE_BITS-1:0]             next_stable_r, next_stable_nxt;
  gha_pkg::result_t                   res_r, res_nxt;

  // Decoded request and memory read data.
  gha_pkg::kind_t      in_kind;
  logic                in_range;
  logic                free_ok;
  logic                fresh_ok;
  logic                find_go;
  logic [IDX_W-1:0]    idx_addr;
  logic [CNT_W-1:0]    free_cnt_dec;
  logic                rd_alive;
  logic [GEN_BITS-1:0] rd_gen;
  logic [STABLE_BITS-1:0] rd_stable;
  logic                gen_match;
  logic                scan_hit;
  logic                scan_last;
  logic [IDX_W-1:0]    scan_inc;
  logic [GEN_BITS-1:0] gen_cur;
  logic [STABLE_BITS-1:0] st_cur;
  logic [STABLE_BITS-1:0] st_inc;

  assign in_kind      = gha_pkg::kind_t'(req_kind);
  assign in_range     = (32'(req_slot_index) < 32'(used_r)) &&
                        (32'(req_slot_index) < 32'(SLOT_COUNT));
  assign free_ok      = (free_count_r != '0) && (free_count_r <= CNT_W'(SLOT_COUNT));
  assign fresh_ok     = used_r < CNT_W'(SLOT_COUNT);
  assign find_go      = (req_search_key != '0) && (used_r != '0);
  assign idx_addr     = IDX_W'(req_slot_index);
  assign free_cnt_dec = free_count_r - CNT_W'(1);

  assign rd_alive  = slot_rd_data[ENTRY_W-1];
  assign rd_gen    = slot_rd_data[STABLE_BITS +: GEN_BITS];
  assign rd_stable = slot_rd_data[STABLE_BITS-1:0];
  assign gen_match = rd_alive && (rd_gen == gen_r);

  assign scan_hit  = rd_alive &&
                     (gha_pkg::KEY_CMP_W'(rd_stable) == gha_pkg::KEY_CMP_W'(key_r));
  assign scan_last = (32'(scan_r) + 32'd1) >= 32'(used_r);
  assign scan_inc  = scan_r + IDX_W'(1);

  // A fresh slot was never written, so its generation is the reset value.
  assign gen_cur = fresh_r ? '0 : rd_gen;
  assign st_cur  = (next_stable_r == '0) ? STABLE_BITS'(1) : next_stable_r;
  assign st_inc  = st_cur + STABLE_BITS'(1);

  assign req_stall = (state_r != gha_pkg::ST_IDLE);
  assign res_valid = (state_r == gha_pkg::ST_DONE);
  assign res       = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gha_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (in_kind)
            gha_pkg::KIND_CREATE: begin
              if (free_ok) begin
                state_nxt = gha_pkg::ST_POP;
              end else if (fresh_ok) begin
                state_nxt = gha_pkg::ST_CREATE;
              end else begin
                state_nxt = gha_pkg::ST_DONE;
              end
            end
            gha_pkg::KIND_DESTROY, gha_pkg::KIND_IS_ALIVE,
            gha_pkg::KIND_GET_STABLE, gha_pkg::KIND_MAKE: begin
              state_nxt = in_range ? gha_pkg::ST_LOOKUP : gha_pkg::ST_DONE;
            end
            gha_pkg::KIND_FIND: begin
              state_nxt = find_go ? gha_pkg::ST_SCAN : gha_pkg::ST_DONE;
            end
            default: begin
              state_nxt = gha_pkg::ST_DONE;
            end
          endcase
        end
      end
      gha_pkg::ST_POP:    state_nxt = gha_pkg::ST_CREATE;
      gha_pkg::ST_CREATE: state_nxt = gha_pkg::ST_DONE;
      gha_pkg::ST_LOOKUP: state_nxt = gha_pkg::ST_DONE;
      gha_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_nxt = gha_pkg::ST_DONE;
        end
      end
      gha_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = gha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gha_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    kind_nxt        = kind_r;
    idx_nxt         = idx_r;
    gen_nxt         = gen_r;
    key_nxt         = key_r;
    slot_nxt        = slot_r;
    fresh_nxt       = fresh_r;
    scan_nxt        = scan_r;
    free_count_nxt  = free_count_r;
    used_nxt        = used_r;
    next_stable_nxt = next_stable_r;
    res_nxt         = res_r;
    slot_rd_en      = 1'b0;
    slot_rd_addr    = '0;
    slot_wr_en      = 1'b0;
    slot_wr_addr    = slot_r;
    slot_wr_data    = '0;
    stk_rd_en       = 1'b0;
    stk_rd_addr     = free_cnt_dec[IDX_W-1:0];
    stk_wr_en       = 1'b0;
    stk_wr_addr     = free_count_r[IDX_W-1:0];
    stk_wr_data     = slot_r;
    case (state_r)
      gha_pkg::ST_IDLE: begin
        if (req_valid) begin
          kind_nxt = in_kind;
          idx_nxt  = req_slot_index;
          gen_nxt  = GEN_BITS'(req_generation);
          key_nxt  = req_search_key;
          res_nxt  = '0;
          case (in_kind)
            gha_pkg::KIND_CREATE: begin
              if (free_ok) begin
                free_count_nxt = free_cnt_dec;
                stk_rd_en      = 1'b1;
                fresh_nxt      = 1'b0;
              end else if (fresh_ok) begin
                slot_nxt  = used_r[IDX_W-1:0];
                used_nxt  = used_r + CNT_W'(1);
                fresh_nxt = 1'b1;
              end else begin
                res_nxt.full_error = 1'b1;
              end
            end
            gha_pkg::KIND_DESTROY, gha_pkg::KIND_IS_ALIVE,
            gha_pkg::KIND_GET_STABLE, gha_pkg::KIND_MAKE: begin
              if (in_range) begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = idx_addr;
                slot_nxt     = idx_addr;
              end
            end
            gha_pkg::KIND_FIND: begin
              if (find_go) begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = '0;
                scan_nxt     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gha_pkg::ST_POP: begin
        slot_nxt     = stk_rd_data;
        slot_rd_en   = 1'b1;
        slot_rd_addr = stk_rd_data;
      end
      gha_pkg::ST_CREATE: begin
        slot_wr_en      = 1'b1;
        slot_wr_data    = {1'b1, gen_cur, st_cur};
        next_stable_nxt = (st_inc == '0) ? STABLE_BITS'(1) : st_inc;
        res_nxt.found      = 1'b1;
        res_nxt.index      = gha_pkg::IDX_FIELD_W'(slot_r);
        res_nxt.generation = gha_pkg::GEN_FIELD_W'(gen_cur);
        res_nxt.stable     = gha_pkg::STABLE_FIELD_W'(st_cur);
        res_nxt.full_error = 1'b0;
      end
      gha_pkg::ST_LOOKUP: begin
        case (kind_r)
          gha_pkg::KIND_DESTROY: begin
            if (gen_match) begin
              slot_wr_en   = 1'b1;
              slot_wr_data = {1'b0, rd_gen + GEN_BITS'(1), {STABLE_BITS{1'b0}}};
              if (free_count_r < CNT_W'(SLOT_COUNT)) begin
                stk_wr_en      = 1'b1;
                free_count_nxt = free_count_r + CNT_W'(1);
              end
              res_nxt.found      = 1'b1;
              res_nxt.index      = idx_r;
              res_nxt.generation = gha_pkg::GEN_FIELD_W'(gen_r);
              res_nxt.stable     = gha_pkg::STABLE_FIELD_W'(rd_stable);
            end
          end
          gha_pkg::KIND_IS_ALIVE, gha_pkg::KIND_GET_STABLE: begin
            if (gen_match) begin
              res_nxt.found      = 1'b1;
              res_nxt.index      = idx_r;
              res_nxt.generation = gha_pkg::GEN_FIELD_W'(rd_gen);
              res_nxt.stable     = gha_pkg::STABLE_FIELD_W'(rd_stable);
            end
          end
          gha_pkg::KIND_MAKE: begin
            if (rd_alive) begin
              res_nxt.found      = 1'b1;
              res_nxt.index      = idx_r;
              res_nxt.generation = gha_pkg::GEN_FIELD_W'(rd_gen);
              res_nxt.stable     = gha_pkg::STABLE_FIELD_W'(rd_stable);
            end
          end
          default: begin
          end
        endcase
      end
      gha_pkg::ST_SCAN: begin
        if (scan_hit) begin
          res_nxt.found      = 1'b1;
          res_nxt.index      = gha_pkg::IDX_FIELD_W'(scan_r);
          res_nxt.generation = gha_pkg::GEN_FIELD_W'(rd_gen);
          res_nxt.stable     = gha_pkg::STABLE_FIELD_W'(rd_stable);
        end else if (!scan_last) begin
          // Read of the next entry overlaps the compare of this one.
          scan_nxt     = scan_inc;
          slot_rd_en   = 1'b1;
          slot_rd_addr = scan_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gha_pkg::ST_IDLE;
      free_count_r  <= '0;
      used_r        <= '0;
      next_stable_r <= STABLE_BITS'(1);
    end else begin
      state_r       <= state_nxt;
      free_count_r  <= free_count_nxt;
      used_r        <= used_nxt;
      next_stable_r <= next_stable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    gen_r   <= gen_nxt;
    key_r   <= key_nxt;
    slot_r  <= slot_nxt;
    fresh_r <= fresh_nxt;
    scan_r  <= scan_nxt;
    res_r   <= res_nxt;
  end

  `ASSERT_ALWAYS(a_free_le_used, free_count_r <= used_r, "free stack holds more slots than were handed out")
  `ASSERT_ALWAYS(a_used_bound, used_r <= CNT_W'(SLOT_COUNT), "used slot count exceeds the table depth")
  `ASSERT_ALWAYS(a_stable_nonzero, next_stable_r != '0, "next stable id is zero")
  `ASSERT_ALWAYS(a_scan_range, (state_r != gha_pkg::ST_SCAN) || (32'(scan_r) < 32'(used_r)), "search walked past the used slots")
  `ASSERT_NEXT(a_create_bump, state_r == gha_pkg::ST_CREATE, next_stable_r != $past(next_stable_r), "create did not advance the stable id")

endmodule

[bench/generational_handle_allocator_tb.sv]
module generational_handle_allocator_tb;

  // The slot store is sized by the block's default parameters.
  localparam int SLOTS = 256;

  // Kinds 6 and 7 are not decoded by the block; they must come back as an all-zero result.
  localparam logic [gha_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [gha_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

  // The slowest legal run is far below this: at most 655 requests, each at worst a full-table
  // search plus the longest sender gap and the longest result stall.
  localparam int CYCLE_LIMIT = 1000000;

  // After the last result we keep watching long enough for a full search to finish, so a
  // stray extra result would still be caught.
  localparam int DRAIN_CYCLES = 300;

  localparam int SHOWN_MISMATCHES = 10;

  localparam gha_pkg::result_t NO_HIT = '0;

  // One row of the directed part. When check_typed is set the expected result is the one
  // written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [gha_pkg::KIND_W-1:0] kind;
    logic [7:0]                 idx;
    logic [15:0]                gen;
    logic [31:0]                key;
    logic                       check_typed;
    gha_pkg::result_t           res;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  // The directed part walks the special cases on an empty store first, then builds three
  // live slots and exercises hits, stale handles, out-of-range handles, double destroy,
  // searches for zero and for a cleared id, and reuse of freed slots in LIFO order.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{gha_pkg::KIND_IS_ALIVE,   8'd0,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_DESTROY,    8'd255, 16'hffff, 32'hffff_ffff, 1'b1, NO_HIT},
    '{gha_pkg::KIND_FIND,       8'd0,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_MAKE,       8'd0,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{KIND_SPARE6,              8'd255, 16'hffff, 32'hffff_ffff, 1'b1, NO_HIT},
    '{KIND_SPARE7,              8'd0,   16'h0000, 32'h0000_0001, 1'b1, NO_HIT},
    '{gha_pkg::KIND_CREATE,     8'd255, 16'hffff, 32'hffff_ffff, 1'b1,
      '{1'b1, 8'd0, 16'd0, 32'd1, 1'b0}},
    '{gha_pkg::KIND_CREATE,     8'd0,   16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd1, 16'd0, 32'd2, 1'b0}},
    '{gha_pkg::KIND_CREATE,     8'd0,   16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd2, 16'd0, 32'd3, 1'b0}},
    '{gha_pkg::KIND_GET_STABLE, 8'd1,   16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd1, 16'd0, 32'd2, 1'b0}},
    '{gha_pkg::KIND_IS_ALIVE,   8'd1,   16'h0001, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_IS_ALIVE,   8'd3,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_FIND,       8'd0,   16'h0000, 32'h0000_0003, 1'b1,
      '{1'b1, 8'd2, 16'd0, 32'd3, 1'b0}},
    '{gha_pkg::KIND_FIND,       8'd0,   16'h0000, 32'hffff_ffff, 1'b1, NO_HIT},
    '{gha_pkg::KIND_MAKE,       8'd2,   16'hffff, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd2, 16'd0, 32'd3, 1'b0}},
    '{gha_pkg::KIND_DESTROY,    8'd1,   16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd1, 16'd0, 32'd2, 1'b0}},
    '{gha_pkg::KIND_DESTROY,    8'd1,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_IS_ALIVE,   8'd1,   16'h0001, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_MAKE,       8'd1,   16'h0000, 32'h0000_0000, 1'b1, NO_HIT},
    '{gha_pkg::KIND_DESTROY,    8'd0,   16'h0000, 32'h0000_0000, 1'b1,
      '{1'b1, 8'd0, 16'd0, 32'd1, 1'b0}},
    '{gha_pkg::KIND_CREATE,     8'd0,   16'h0000, 32'h0000_0000, 1'b0, NO_HIT},
    '{gha_pkg::KIND_CREATE,     8'd0,   16'h0000, 32'h0000_0000, 1'b0, NO_HIT},
    '{gha_pkg::KIND_CREATE,     8'd0,   16'h0000, 32'h0000_0000, 1'b0, NO_HIT},
    '{gha_pkg::KIND_FIND,       8'd0,   16'h0000, 32'h0000_0002, 1'b1, NO_HIT},
    '{gha_pkg::KIND_GET_STABLE, 8'd0,   16'h0001, 32'h0000_0000, 1'b0, NO_HIT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_slot_index = '0;
  logic [15:0] in_handle_generation = '0;
  logic [31:0] in_search_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [7:0]  out_index;
  logic [15:0] out_generation;
  logic [31:0] out_stable;
  logic        out_full_error;

  generational_handle_allocator i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_slot_index        (in_slot_index),
    .in_handle_generation (in_handle_generation),
    .in_search_key        (in_search_key),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_found            (out_found),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_stable           (out_stable),
    .out_full_error       (out_full_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: per-slot generation, alive mark and stable id, the free
  // stack, the number of slots ever handed out fresh and the next stable id to give out.
  logic [15:0] gen_mirror    [SLOTS];
  bit          alive_mirror  [SLOTS];
  logic [31:0] stable_mirror [SLOTS];
  logic [7:0]  free_mirror   [SLOTS];
  int          free_top    = 0;
  int          fresh_count = 0;
  logic [31:0] next_id     = 32'd1;

  // Number of creates predicted to fail because the store was full.
  int          full_hits = 0;

  gha_pkg::result_t expected_results [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  bit               sender_calm = 1'b0;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      gen_mirror[s]    = '0;
      alive_mirror[s]  = 1'b0;
      stable_mirror[s] = '0;
      free_mirror[s]   = '0;
    end
  end

  // Works out the result of one accepted request and advances the shadow state, exactly
  // as the block must.
  function automatic gha_pkg::result_t allocator_response(input logic [2:0] k,
                                                          input logic [7:0] idx,
                                                          input logic [15:0] gen,
                                                          input logic [31:0] key);
    gha_pkg::result_t r;
    logic [7:0]       slot;
    logic [31:0]      id;
    bit               live;
    r = NO_HIT;
    live = (idx < fresh_count) && alive_mirror[idx];
    case (k)
      gha_pkg::KIND_CREATE: begin
        // Freed slots are reused last-in first-out before any fresh slot is taken.
        if (free_top > 0) begin
          free_top--;
          slot = free_mirror[free_top];
        end else if (fresh_count < SLOTS) begin
          slot = fresh_count[7:0];
          fresh_count++;
        end else begin
          // Full: flag the error and leave the state alone.
          r.full_error = 1'b1;
          full_hits++;
          return r;
        end
        // Stable ids skip zero when the counter wraps.
        id = (next_id == '0) ? 32'd1 : next_id;
        next_id = id + 32'd1;
        if (next_id == '0) next_id = 32'd1;
        alive_mirror[slot]  = 1'b1;
        stable_mirror[slot] = id;
        r = '{1'b1, slot, gen_mirror[slot], id, 1'b0};
      end
      gha_pkg::KIND_DESTROY: begin
        // The result carries the generation of the handle and the id that was cleared.
        if (live && gen_mirror[idx] == gen) begin
          r = '{1'b1, idx, gen, stable_mirror[idx], 1'b0};
          stable_mirror[idx] = '0;
          alive_mirror[idx]  = 1'b0;
          gen_mirror[idx]    = gen_mirror[idx] + 16'd1;
          if (free_top < SLOTS) begin
            free_mirror[free_top] = idx;
            free_top++;
          end
        end
      end
      gha_pkg::KIND_IS_ALIVE, gha_pkg::KIND_GET_STABLE: begin
        if (live && gen_mirror[idx] == gen) begin
          r = '{1'b1, idx, gen_mirror[idx], stable_mirror[idx], 1'b0};
        end
      end
      gha_pkg::KIND_FIND: begin
        // A key of zero never matches; with duplicate ids the lowest live slot wins.
        if (key != '0) begin
          for (int s = 0; s < fresh_count; s++) begin
            if (alive_mirror[s] && stable_mirror[s] == key) begin
              r = '{1'b1, s[7:0], gen_mirror[s], stable_mirror[s], 1'b0};
              break;
            end
          end
        end
      end
      gha_pkg::KIND_MAKE: begin
        if (live) begin
          r = '{1'b1, idx, gen_mirror[idx], stable_mirror[idx], 1'b0};
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Idle length for either side: mostly short, sometimes longer, rarely a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic int any_live_slot();
    int start;
    int s;
    start = $urandom_range(0, SLOTS - 1);
    for (int j = 0; j < SLOTS; j++) begin
      s = (start + j) % SLOTS;
      if (s < fresh_count && alive_mirror[s]) return s;
    end
    return -1;
  endfunction

  // Builds one random request. Most requests that name a handle name a live one with its
  // current generation, so destroys and queries really hit; the rest are noise: stale
  // generations, dead or never-used slots, zero or cleared search keys, fully random fields.
  // While filling, creates dominate so the store reaches the full condition.
  task automatic next_random_request(input bit filling, output logic [2:0] k,
                                     output logic [7:0] idx, output logic [15:0] gen,
                                     output logic [31:0] key);
    int unsigned pick;
    int          s;
    pick = $urandom_range(0, 99);
    if (filling) begin
      if (pick < 82)      k = gha_pkg::KIND_CREATE;
      else if (pick < 88) k = gha_pkg::KIND_DESTROY;
      else if (pick < 91) k = gha_pkg::KIND_IS_ALIVE;
      else if (pick < 94) k = gha_pkg::KIND_GET_STABLE;
      else if (pick < 97) k = gha_pkg::KIND_FIND;
      else if (pick < 99) k = gha_pkg::KIND_MAKE;
      else                k = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
    end else begin
      if (pick < 24)      k = gha_pkg::KIND_CREATE;
      else if (pick < 48) k = gha_pkg::KIND_DESTROY;
      else if (pick < 60) k = gha_pkg::KIND_IS_ALIVE;
      else if (pick < 72) k = gha_pkg::KIND_GET_STABLE;
      else if (pick < 84) k = gha_pkg::KIND_FIND;
      else if (pick < 97) k = gha_pkg::KIND_MAKE;
      else                k = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
    end
    idx = 8'($urandom_range(0, 255));
    gen = 16'($urandom);
    key = $urandom;
    if (k == gha_pkg::KIND_CREATE || k == KIND_SPARE6 || k == KIND_SPARE7) return;
    if ($urandom_range(0, 4) != 0) begin
      s = any_live_slot();
      if (s >= 0) begin
        idx = 8'(s);
        gen = gen_mirror[s];
        key = stable_mirror[s];
      end
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          // Fully random fields.
        end
        1: begin
          // A slot in the used range, with its current or the next generation, and a key
          // that may be zero or the id of a destroyed slot.
          if (fresh_count > 0) idx = 8'($urandom_range(0, fresh_count - 1));
          gen = gen_mirror[idx] + 16'($urandom_range(0, 1));
          key = $urandom_range(0, next_id);
        end
        default: begin
          // At or beyond the used range.
          idx = 8'($urandom_range((fresh_count < SLOTS) ? fresh_count : 0, 255));
          key = '0;
        end
      endcase
    end
  endtask

  // Presents one request, holds it until the block takes it, records what it must answer,
  // then idles for the given number of cycles. With no idle the next request goes out at
  // the same clock edge, so valid stays high without a glitch.
  task automatic send_request(input logic [2:0] k, input logic [7:0] idx,
                              input logic [15:0] gen, input logic [31:0] key,
                              input bit use_typed, input gha_pkg::result_t typed_res,
                              input int unsigned gap);
    gha_pkg::result_t predicted;
    in_valid             <= 1'b1;
    in_kind              <= k;
    in_slot_index        <= idx;
    in_handle_generation <= gen;
    in_search_key        <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = allocator_response(k, idx, gen, key);
    expected_results.push_back(use_typed ? typed_res : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int unsigned sender_gap();
    if (sender_calm || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // The receiver stalls in random bursts, with occasional long calm stretches.
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;

  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      else if ($urandom_range(0, 2) == 0) stall_left = idle_length();
    end
  end

  // Every accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin : check_results
    gha_pkg::result_t seen;
    gha_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_found, out_index, out_generation, out_stable, out_full_error};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES) begin
          $display("unexpected result at cycle %0d: found=%0b index=%0d gen=%0d stable=%h err=%0b",
                   cycle_count, seen.found, seen.index, seen.generation, seen.stable,
                   seen.full_error);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.found !== want.found || seen.index !== want.index ||
            seen.generation !== want.generation || seen.stable !== want.stable ||
            seen.full_error !== want.full_error) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("mismatch at cycle %0d: expected found=%0b index=%0d gen=%0d stable=%h err=%0b",
                     cycle_count, want.found, want.index, want.generation, want.stable,
                     want.full_error);
            $display("                      actual   found=%0b index=%0d gen=%0d stable=%h err=%0b",
                     seen.found, seen.index, seen.generation, seen.stable, seen.full_error);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]  k;
    logic [7:0]  idx;
    logic [15:0] gen;
    logic [31:0] key;
    int          n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(DIRECTED[r].kind, DIRECTED[r].idx, DIRECTED[r].gen, DIRECTED[r].key,
                   DIRECTED[r].check_typed, DIRECTED[r].res, sender_gap());
    end

    // Fill phase: mostly creates until six creates have been refused on a full store (or 450
    // requests have gone out), with some destroys so freed slots are reused along the way.
    n = 0;
    while (full_hits < 6 && n < 450) begin
      if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      next_random_request(1'b1, k, idx, gen, key);
      send_request(k, idx, gen, key, 1'b0, NO_HIT, sender_gap());
      n++;
    end

    // Hold the sender until every outstanding result has come back.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);

    // Mixed phase on a nearly full store: destroys and creates balance, queries hit and miss.
    for (n = 0; n < 180; n++) begin
      if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      next_random_request(1'b0, k, idx, gen, key);
      send_request(k, idx, gen, key, 1'b0, NO_HIT, (n == 179) ? 1 : sender_gap());
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
